FILE: src/mrts_pkg.sv
// ----------------------------------------------------------------------------
// mrts_pkg: shared types and constants for the mesh route table selector
// Holds field widths, status and request codes, the table entry type and the
// node ID check used on inserts.
// ----------------------------------------------------------------------------
package mrts_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int ID_W    = 8;
  localparam int HOPS_W  = 8;
  localparam int RSSI_W  = 9;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [ID_W-1:0] ID_BCAST = 8'hFF;
  localparam logic [ID_W-1:0] ID_MAX   = 8'hAA;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE = 2'd2;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;

  localparam logic [1:0] REG_OWN_ADDR  = 2'd0;
  localparam logic [1:0] REG_MASTER_ID = 2'd1;
  localparam logic [1:0] REG_AGE_LIMIT = 2'd2;

  localparam logic [ID_W-1:0]   OWN_ADDR_RST  = 8'd0;
  localparam logic [ID_W-1:0]   MASTER_ID_RST = 8'd184;
  localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd62000;

  typedef struct packed {
    logic [ID_W-1:0]          node;
    logic [HOPS_W-1:0]        hops;
    logic [ID_W-1:0]          via;
    logic signed [RSSI_W-1:0] strength;
    logic [TIME_W-1:0]        stamp;
  } entry_t;

  // Valid IDs are nonzero multiples of 0x11 up to 0xAA, the master and broadcast.
  // A byte is a multiple of 0x11 exactly when both nibbles match.
  function automatic logic id_ok(input logic [ID_W-1:0] id,
                                 input logic [ID_W-1:0] master);
    logic mult;
    mult = (id != '0) && (id[7:4] == id[3:0]) && (id <= ID_MAX);
    return (id == master) || (id == ID_BCAST) || mult;
  endfunction

endpackage

FILE: src/mesh_route_table_selector.sv
// ----------------------------------------------------------------------------
// mesh_route_table_selector: minimum-hop mesh route table
// Stores neighbor reports, ages out stale entries and picks the route to the
// master with one entry scan unit that visits a table entry per cycle.
// An accepted item runs the aging pass, then the best-RSSI pass unless the first
// pass settles the route, then the decision state; a rejected insert skips them.
// No new item is accepted until the result is taken; the shared entry scan
// unit, one table entry per cycle over up to two passes, bounds the item rate.
// Reset (rst_n low, synchronous) empties the table, zeroes the route and
// loads the register defaults.
// ----------------------------------------------------------------------------
module mesh_route_table_selector
  import mrts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [7:0] node_id, [15:8] hops, [23:16] hop_id, [32:24] rssi,
  // [64:33] now_ms, [71:65] zero
  input  logic [71:0]       in_tdata,
  // [0] req_type
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [7:0] route_hops, [15:8] route_next, [24:16] route_rssi, [31:25] zero
  output logic [31:0]       out_tdata,
  // [1:0] status
  output logic [STAT_W-1:0] out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGE  = 3'd1;
  localparam logic [2:0] S_BEST = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [2:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [ID_W-1:0]          own_r, master_r;
  logic [TIME_W-1:0]        age_lim_r;
  logic [TIME_W-1:0]        now_r, now_nxt;

  entry_t                   tbl_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic                     any_r, any_nxt;
  logic                     master_seen_r, master_seen_nxt;
  logic                     have_min_r, have_min_nxt;
  logic [HOPS_W-1:0]        min_r, min_nxt;
  logic                     found_r, found_nxt;
  logic signed [RSSI_W-1:0] best_rssi_r, best_rssi_nxt;
  logic [ID_W-1:0]          best_node_r, best_node_nxt;

  logic [HOPS_W-1:0]        cur_hops_r, cur_hops_nxt;
  logic [ID_W-1:0]          cur_next_r, cur_next_nxt;
  logic signed [RSSI_W-1:0] cur_rssi_r, cur_rssi_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;

  logic                     in_acc, cfg_wr;
  entry_t                   in_ent;
  logic                     ids_good, slot_in_range, tbl_wr;
  logic [3:0]               slot;

  entry_t                   scan_ent;
  logic                     scan_live, scan_expired, scan_keep;
  logic [TIME_W-1:0]        scan_age;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, cur_rssi_r, cur_next_r, cur_hops_r};
  assign out_tuser  = status_r;
  assign cfg_pready = 1'b1;

  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_ent.node     = in_tdata[7:0];
  assign in_ent.hops     = in_tdata[15:8];
  assign in_ent.via      = in_tdata[23:16];
  assign in_ent.strength = in_tdata[32:24];
  assign in_ent.stamp    = in_tdata[64:33];

  assign ids_good      = id_ok(in_ent.node, master_r) && id_ok(in_ent.via, master_r);
  assign slot          = (in_ent.node == master_r) ? 4'd0 : in_ent.node[7:4];
  assign slot_in_range = int'(slot) < TABLE_ENTRIES;
  assign tbl_wr        = in_acc && (in_tuser == REQ_INSERT) && ids_good && slot_in_range;

  assign scan_ent     = tbl_r[idx_r];
  assign scan_live    = valid_r[idx_r];
  assign scan_age     = now_r - scan_ent.stamp;
  assign scan_expired = scan_live && !scan_age[TIME_W-1] && (scan_age > age_lim_r);
  assign scan_keep    = scan_live && !scan_expired;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_OWN_ADDR:  cfg_prdata = {24'd0, own_r};
      REG_MASTER_ID: cfg_prdata = {24'd0, master_r};
      REG_AGE_LIMIT: cfg_prdata = age_lim_r;
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    now_nxt         = now_r;
    any_nxt         = any_r;
    master_seen_nxt = master_seen_r;
    have_min_nxt    = have_min_r;
    min_nxt         = min_r;
    found_nxt       = found_r;
    best_rssi_nxt   = best_rssi_r;
    best_node_nxt   = best_node_r;
    cur_hops_nxt    = cur_hops_r;
    cur_next_nxt    = cur_next_r;
    cur_rssi_nxt    = cur_rssi_r;
    status_nxt      = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt         = in_ent.stamp;
          idx_nxt         = '0;
          any_nxt         = 1'b0;
          master_seen_nxt = 1'b0;
          have_min_nxt    = 1'b0;
          min_nxt         = '0;
          found_nxt       = 1'b0;
          best_rssi_nxt   = '0;
          best_node_nxt   = '0;
          if (in_tuser == REQ_INSERT && !ids_good) begin
            status_nxt = ST_BAD_ID;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_AGE;
          end
        end
      end
      S_AGE: begin
        if (scan_keep) begin
          any_nxt = 1'b1;
          if (scan_ent.node == master_r) begin
            master_seen_nxt = 1'b1;
          end
          if (scan_ent.hops != '0 && (!have_min_r || scan_ent.hops < min_r)) begin
            min_nxt      = scan_ent.hops;
            have_min_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt = '0;
          if (!any_nxt || master_seen_nxt || !have_min_nxt) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_BEST;
          end
        end
      end
      S_BEST: begin
        if (scan_live && scan_ent.hops == min_r && scan_ent.via != own_r &&
            (!found_r || scan_ent.strength > best_rssi_r)) begin
          found_nxt     = 1'b1;
          best_rssi_nxt = scan_ent.strength;
          best_node_nxt = scan_ent.node;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_OUT;
        if (!any_r) begin
          cur_hops_nxt = '0;
          cur_next_nxt = '0;
          cur_rssi_nxt = '0;
          status_nxt   = ST_NO_ROUTE;
        end else if (master_seen_r) begin
          cur_hops_nxt = HOPS_W'(1);
          cur_next_nxt = master_r;
          status_nxt   = ST_OK;
        end else if (!have_min_r || !found_r) begin
          status_nxt = ST_NO_ROUTE;
        end else begin
          cur_hops_nxt = min_r + 1'b1;
          cur_next_nxt = best_node_r;
          cur_rssi_nxt = best_rssi_r;
          status_nxt   = ST_OK;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      valid_r    <= '0;
      cur_hops_r <= '0;
      cur_next_r <= '0;
      cur_rssi_r <= '0;
      status_r   <= ST_OK;
      own_r      <= OWN_ADDR_RST;
      master_r   <= MASTER_ID_RST;
      age_lim_r  <= AGE_LIMIT_RST;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      cur_hops_r <= cur_hops_nxt;
      cur_next_r <= cur_next_nxt;
      cur_rssi_r <= cur_rssi_nxt;
      status_r   <= status_nxt;
      if (tbl_wr) begin
        valid_r[IDX_W'(slot)] <= 1'b1;
      end
      if (state_r == S_AGE && scan_expired) begin
        valid_r[idx_r] <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_OWN_ADDR:  own_r     <= cfg_pwdata[ID_W-1:0];
          REG_MASTER_ID: master_r  <= cfg_pwdata[ID_W-1:0];
          REG_AGE_LIMIT: age_lim_r <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    any_r         <= any_nxt;
    master_seen_r <= master_seen_nxt;
    have_min_r    <= have_min_nxt;
    min_r         <= min_nxt;
    found_r       <= found_nxt;
    best_rssi_r   <= best_rssi_nxt;
    best_node_r   <= best_node_nxt;
    if (tbl_wr) begin
      tbl_r[IDX_W'(slot)] <= in_ent;
    end
  end

  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an item was accepted");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("block not idle after a result was taken");

  a_bad_id_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_INSERT && !ids_good)
      |=> (out_tvalid && out_tuser == ST_BAD_ID))
    else $error("rejected insert did not report at once");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the mesh route table selector
// Runs a directed table of neighbor reports and refreshes, then random
// phases under several register settings. Each result item is compared with
// its row's expected values or a local route table predictor, with random idling
// on both sides but in one phase, and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import mrts_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int STUCK_LIMIT   = 5000;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [ID_W-1:0] ID_STEP = 8'h11;

  typedef struct packed {
    logic                     req;
    logic [ID_W-1:0]          node;
    logic [HOPS_W-1:0]        hops;
    logic [ID_W-1:0]          via;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        now;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [HOPS_W-1:0]        hops;
    logic [ID_W-1:0]          next_id;
    logic signed [RSSI_W-1:0] rssi;
  } route_report_t;

  typedef struct packed {
    req_item_t     item;
    logic          typed;
    route_report_t want;
  } plan_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // [7:0] node_id, [15:8] hops, [23:16] hop_id, [32:24] rssi,
  // [64:33] now_ms, [71:65] zero
  logic [71:0]       in_tdata    = '0;
  // [0] req_type
  logic              in_tuser    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  // [7:0] route_hops, [15:8] route_next, [24:16] route_rssi, [31:25] zero
  logic [31:0]       out_tdata;
  // [1:0] status
  logic [STAT_W-1:0] out_tuser;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  mesh_route_table_selector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: register copies, neighbor table and current route.
  logic [ID_W-1:0]          local_id    = OWN_ADDR_RST;
  logic [ID_W-1:0]          master_node = MASTER_ID_RST;
  logic [TIME_W-1:0]        age_window  = AGE_LIMIT_RST;
  bit                       nbr_live  [TABLE_ENTRIES];
  logic [ID_W-1:0]          nbr_node  [TABLE_ENTRIES];
  logic [HOPS_W-1:0]        nbr_hops  [TABLE_ENTRIES];
  logic [ID_W-1:0]          nbr_via   [TABLE_ENTRIES];
  logic signed [RSSI_W-1:0] nbr_rssi  [TABLE_ENTRIES];
  logic [TIME_W-1:0]        nbr_stamp [TABLE_ENTRIES];
  logic [HOPS_W-1:0]        cur_hops  = '0;
  logic [ID_W-1:0]          cur_next  = '0;
  logic signed [RSSI_W-1:0] cur_rssi  = '0;

  route_report_t pending_routes[$];
  plan_row_t     plan_rows[$];
  int            routes_seen  = 0;
  int            mismatch_cnt = 0;
  int            stuck_cycles = 0;
  bit            no_idle      = 1'b0;
  int            step_max     = 1000;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      nbr_live[i]  = 1'b0;
      nbr_node[i]  = '0;
      nbr_hops[i]  = '0;
      nbr_via[i]   = '0;
      nbr_rssi[i]  = '0;
      nbr_stamp[i] = '0;
    end
  end

  function automatic bit id_valid(input logic [ID_W-1:0] id);
    return (id == master_node) || (id == ID_BCAST) ||
           (id != '0 && (id % ID_STEP) == 0 && id <= ID_MAX);
  endfunction

  // Ages the table, then picks the route and returns the status code.
  function automatic logic [STAT_W-1:0] reselect(input logic [TIME_W-1:0] now);
    int age;
    bit any_live, has_master, have_min, found;
    logic [HOPS_W-1:0] min_h;
    logic [ID_W-1:0] best_node;
    logic signed [RSSI_W-1:0] best_rssi;
    any_live   = 1'b0;
    has_master = 1'b0;
    have_min   = 1'b0;
    found      = 1'b0;
    min_h      = '0;
    best_node  = '0;
    best_rssi  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nbr_live[i]) begin
        age = int'(now - nbr_stamp[i]);
        if (longint'(age) > longint'({32'd0, age_window})) begin
          nbr_live[i]  = 1'b0;
          nbr_node[i]  = '0;
          nbr_hops[i]  = '0;
          nbr_via[i]   = '0;
          nbr_rssi[i]  = '0;
          nbr_stamp[i] = '0;
        end
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nbr_live[i]) begin
        any_live = 1'b1;
        if (nbr_node[i] == master_node) has_master = 1'b1;
        if (nbr_hops[i] != '0 && (!have_min || nbr_hops[i] < min_h)) begin
          min_h    = nbr_hops[i];
          have_min = 1'b1;
        end
      end
    end
    if (!any_live) begin
      cur_hops = '0;
      cur_next = '0;
      cur_rssi = '0;
      return ST_NO_ROUTE;
    end
    if (has_master) begin
      cur_hops = 8'd1;
      cur_next = master_node;
      return ST_OK;
    end
    if (!have_min) return ST_NO_ROUTE;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nbr_live[i] && nbr_hops[i] == min_h && nbr_via[i] != local_id &&
          (!found || nbr_rssi[i] > best_rssi)) begin
        found     = 1'b1;
        best_rssi = nbr_rssi[i];
        best_node = nbr_node[i];
      end
    end
    if (!found) return ST_NO_ROUTE;
    cur_hops = min_h + 8'd1;
    cur_next = best_node;
    cur_rssi = best_rssi;
    return ST_OK;
  endfunction

  function automatic route_report_t predict_route(input req_item_t it);
    route_report_t r;
    int slot;
    if (it.req == REQ_INSERT && (!id_valid(it.node) || !id_valid(it.via))) begin
      r.status = ST_BAD_ID;
    end else begin
      if (it.req == REQ_INSERT) begin
        slot = (it.node == master_node) ? 0 : int'(it.node[7:4]);
        if (slot < TABLE_ENTRIES) begin
          nbr_live[slot]  = 1'b1;
          nbr_node[slot]  = it.node;
          nbr_hops[slot]  = it.hops;
          nbr_via[slot]   = it.via;
          nbr_rssi[slot]  = it.rssi;
          nbr_stamp[slot] = it.now;
        end
      end
      r.status = reselect(it.now);
    end
    r.hops    = cur_hops;
    r.next_id = cur_next;
    r.rssi    = cur_rssi;
    return r;
  endfunction

  task automatic send_item(input req_item_t it, input logic typed,
                           input route_report_t want);
    int gap;
    route_report_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req;
    in_tdata  <= {7'd0, it.now, it.rssi, it.via, it.hops, it.node};
    do @(posedge clk); while (!in_tready);
    predicted = predict_route(it);
    pending_routes.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic req, input int node, input int hops, input int via,
                         input int rssi, input logic [TIME_W-1:0] now, input logic typed,
                         input logic [STAT_W-1:0] st, input int h, input int nh,
                         input int r);
    plan_row_t row;
    row.item.req     = req;
    row.item.node    = 8'(node);
    row.item.hops    = 8'(hops);
    row.item.via     = 8'(via);
    row.item.rssi    = 9'(rssi);
    row.item.now     = now;
    row.typed        = typed;
    row.want.status  = st;
    row.want.hops    = 8'(h);
    row.want.next_id = 8'(nh);
    row.want.rssi    = 9'(r);
    plan_rows.push_back(row);
  endtask

  task automatic play_rows();
    foreach (plan_rows[i]) send_item(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].want);
    plan_rows.delete();
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_OWN_ADDR:  local_id    = value[ID_W-1:0];
      REG_MASTER_ID: master_node = value[ID_W-1:0];
      REG_AGE_LIMIT: age_window  = value[TIME_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return master_node;
    if (r < 10) return ID_BCAST;
    return 8'(ID_STEP * $urandom_range(1, 10));
  endfunction

  // Mostly well-formed inserts with plausible hop counts and slowly moving
  // time, mixed with refreshes, malformed reports and time jumps.
  function automatic req_item_t draw_item();
    req_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    it.now  = clock_ms;
    it.rssi = 9'($urandom);
    it.node = 8'($urandom);
    it.via  = 8'($urandom);
    it.hops = 8'($urandom);
    if (r < 12) begin
      it.req = REQ_REFRESH;
    end else begin
      it.req = REQ_INSERT;
      if (r >= 20) begin
        it.node = pick_id();
        it.via  = ($urandom_range(0, 3) == 0) ? local_id : pick_id();
        r = $urandom_range(0, 99);
        if (r < 10) it.hops = '0;
        else if (r < 70) it.hops = 8'($urandom_range(1, 4));
        else if (r < 80) it.hops = 8'($urandom_range(254, 255));
      end
    end
    return it;
  endfunction

  task automatic run_phase(input logic [ID_W-1:0] own, input logic [ID_W-1:0] master,
                           input logic [TIME_W-1:0] age, input int count, input bit fast);
    route_report_t none;
    none = '0;
    wait_idle();
    cfg_write(REG_OWN_ADDR, {24'd0, own});
    cfg_write(REG_MASTER_ID, {24'd0, master});
    cfg_write(REG_AGE_LIMIT, age);
    if (age == '0) step_max = 2;
    else if (age > 32'd1000000) step_max = 5000;
    else step_max = int'(age / 25) + 1;
    no_idle = fast;
    repeat (count) send_item(draw_item(), 1'b0, none);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //       req          node   hops  via    rssi  now           typed status       hops next rssi
    add_row(REQ_REFRESH, 8'h00, 0,    8'h00, 0,    32'd0,        1, ST_NO_ROUTE, 0, 0,     0);
    add_row(REQ_INSERT,  8'h12, 1,    8'h11, 0,    32'd10,       1, ST_BAD_ID,   0, 0,     0);
    add_row(REQ_INSERT,  8'h11, 1,    8'h00, 0,    32'd20,       1, ST_BAD_ID,   0, 0,     0);
    add_row(REQ_INSERT,  8'h11, 3,    8'h22, -50,  32'd100,      1, ST_OK,       4, 8'h11, -50);
    add_row(REQ_INSERT,  8'h22, 3,    8'h33, 20,   32'd200,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'h33, 3,    8'h44, 20,   32'd300,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'h44, 2,    8'h55, -100, 32'd400,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'hB8, 5,    8'hFF, 255,  32'd500,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'hFF, 255,  8'hFF, -256, 32'd600,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'hAA, 0,    8'h11, 0,    32'd700,      0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'hFF, 7,    8'h12, 3,    32'd800,      0, ST_OK,       0, 0,     0);
    add_row(REQ_REFRESH, 8'hFF, 255,  8'hFF, -1,   32'hFFFFFFFF, 0, ST_OK,       0, 0,     0);
    add_row(REQ_REFRESH, 8'h00, 0,    8'h00, 0,    32'h7FFFFFFF, 1, ST_NO_ROUTE, 0, 0,     0);
    add_row(REQ_INSERT,  8'h66, 0,    8'h77, 100,  32'h7FFFFFFF, 1, ST_NO_ROUTE, 0, 0,     0);
    add_row(REQ_INSERT,  8'h55, 255,  8'h11, -1,   32'h7FFFFFFF, 1, ST_OK,       0, 8'h55, -1);
    add_row(REQ_REFRESH, 8'h00, 0,    8'h00, 0,    32'h8000F26F, 0, ST_OK,       0, 0,     0);
    add_row(REQ_REFRESH, 8'h00, 0,    8'h00, 0,    32'h8000F270, 1, ST_NO_ROUTE, 0, 0,     0);
    add_row(REQ_INSERT,  8'h99, 1,    8'h88, 255,  32'd5,        1, ST_OK,       2, 8'h99, 255);
    add_row(REQ_INSERT,  8'h11, 1,    8'hAA, 254,  32'd5,        0, ST_OK,       0, 0,     0);
    play_rows();

    // With this node at 0x88, relays that route through it are skipped.
    wait_idle();
    cfg_write(REG_OWN_ADDR, 32'h88);
    add_row(REQ_REFRESH, 8'h00, 0,    8'h00, 0,    32'd6,        0, ST_OK,       0, 0,     0);
    add_row(REQ_INSERT,  8'h11, 1,    8'h88, 0,    32'd7,        0, ST_OK,       0, 0,     0);
    play_rows();

    run_phase(8'h33, MASTER_ID_RST, AGE_LIMIT_RST, 180, 1'b0);
    run_phase(8'h22, 8'h11, 32'd1000, 180, 1'b1);
    run_phase(8'hFF, 8'h00, 32'd0, 180, 1'b0);
    run_phase(8'h00, 8'hFF, 32'hFFFFFFFF, 150, 1'b0);
    run_phase(8'(ID_STEP * $urandom_range(1, 10)), 8'($urandom),
              $urandom_range(100, 20000), 180, 1'b0);
    run_phase(8'h55, MASTER_ID_RST, AGE_LIMIT_RST, 200, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_routes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    route_report_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (routes_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      routes_seen++;
      if (pending_routes.size() == 0) begin
        $error("route item with no request outstanding");
        mismatch_cnt++;
      end else begin
        want = pending_routes.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          mismatch_cnt++;
        end
        if (out_tdata[7:0] !== want.hops) begin
          $error("route_hops: expected %0d, actual %0d", want.hops, out_tdata[7:0]);
          mismatch_cnt++;
        end
        if (out_tdata[15:8] !== want.next_id) begin
          $error("route_next: expected 0x%02h, actual 0x%02h", want.next_id, out_tdata[15:8]);
          mismatch_cnt++;
        end
        if (out_tdata[24:16] !== want.rssi) begin
          $error("route_rssi: expected %0d, actual %0d", want.rssi, $signed(out_tdata[24:16]));
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

FILE: files.f
src/mrts_pkg.sv
src/mesh_route_table_selector.sv
dv/testbench.sv
